// File: design/first_fit_bank_allocator_macros.svh
// Assertion macros used by the checker file of the bank allocator.
`ifndef FIRST_FIT_BANK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BANK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define FFBA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define FFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ffba_pkg.sv
// Types and constants of the first-fit bank allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffba_pkg;

  localparam logic [4:0] SHIFT_MIN      = 5'd4;
  localparam logic [4:0] SHIFT_MAX      = 5'd20;
  localparam logic [4:0] RESET_SHIFT    = 5'd12;
  localparam logic [7:0] RESET_HEADER   = 8'd32;
  localparam logic [6:0] RESET_RESERVED = 7'd1;
  localparam logic [6:0] RESET_TOTAL    = 7'd64;

  typedef enum logic [1:0] {
    CFG_BANK_SHIFT     = 2'd0,
    CFG_HEADER_BYTES   = 2'd1,
    CFG_RESERVED_BANKS = 2'd2,
    CFG_TOTAL_BANKS    = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NO_ROOM = 2'd1,
    STATUS_UNKNOWN = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_WALK  = 2'd1,
    S_SPLIT = 2'd2,
    S_DONE  = 2'd3
  } state_e;

  typedef enum logic [2:0] {
    WR_NONE   = 3'd0,
    WR_HIT    = 3'd1,
    WR_SPLIT  = 3'd2,
    WR_FREE   = 3'd3,
    WR_APPEND = 3'd4
  } wr_op_e;

  typedef struct packed {
    logic   load;
    logic   step;
    wr_op_e wr_op;
    logic   fail;
  } ffba_cmd_t;

  typedef struct packed {
    logic in_range;
    logic is_free_req;
    logic alloc_fit;
    logic free_match;
    logic need_split;
    logic tail_fit;
  } ffba_sts_t;

endpackage
`default_nettype wire

// File: design/ffba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ffba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: design/ffba_ctrl.sv
// Sequencer of the bank allocator: request accept, block walk, split and result.
`timescale 1ns / 1ps
`default_nettype none
module ffba_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire ffba_pkg::ffba_sts_t sts_i,
  output ffba_pkg::ffba_cmd_t      cmd_o,
  output logic                     busy_o,
  output logic                     done_o
);
  import ffba_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE, S_DONE: begin
        state_d = start_i ? S_WALK : S_IDLE;
      end
      S_WALK: begin
        if (sts_i.in_range && !sts_i.is_free_req && sts_i.alloc_fit) begin
          state_d = sts_i.need_split ? S_SPLIT : S_DONE;
        end else if (sts_i.in_range && sts_i.is_free_req && sts_i.free_match) begin
          state_d = S_DONE;
        end else if (!sts_i.in_range) begin
          state_d = S_DONE;
        end
      end
      S_SPLIT: begin
        state_d = S_DONE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o  = '{load: 1'b0, step: 1'b0, wr_op: WR_NONE, fail: 1'b0};
    busy_o = 1'b0;
    done_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load = start_i;
      end
      S_DONE: begin
        done_o     = 1'b1;
        cmd_o.load = start_i;
      end
      S_WALK: begin
        busy_o = 1'b1;
        if (sts_i.in_range && !sts_i.is_free_req && sts_i.alloc_fit) begin
          cmd_o.wr_op = WR_HIT;
        end else if (sts_i.in_range && sts_i.is_free_req && sts_i.free_match) begin
          cmd_o.wr_op = WR_FREE;
        end else if (sts_i.in_range) begin
          cmd_o.step = 1'b1;
        end else if (!sts_i.is_free_req && sts_i.tail_fit) begin
          cmd_o.wr_op = WR_APPEND;
        end else begin
          cmd_o.fail = 1'b1;
        end
      end
      S_SPLIT: begin
        busy_o      = 1'b1;
        cmd_o.wr_op = WR_SPLIT;
      end
      default: begin
        busy_o = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: design/ffba_datapath.sv
// Datapath of the bank allocator: registers, block table, sizing and results.
`timescale 1ns / 1ps
`default_nettype none
module ffba_datapath #(
  parameter int unsigned NUM_BANKS = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_addr_i,
  input  wire logic [7:0]          cfg_wdata_i,
  input  wire logic                req_type_i,
  input  wire logic [25:0]         request_bytes_i,
  input  wire logic [25:0]         free_offset_i,
  input  wire ffba_pkg::ffba_cmd_t cmd_i,
  output ffba_pkg::ffba_sts_t      sts_o,
  output logic [1:0]               status_o,
  output logic [5:0]               start_bank_o,
  output logic [25:0]              payload_offset_o,
  output logic [63:0]              new_active_mask_o
);
  import ffba_pkg::*;

  localparam int unsigned CNT_W  = $clog2(NUM_BANKS + 1);
  localparam int unsigned IDX_W  = $clog2(NUM_BANKS);
  localparam int unsigned NEED_W = CNT_W + 1;
  localparam int unsigned ENT_W  = CNT_W + 1;
  localparam logic [CNT_W-1:0]     BANKS_C  = CNT_W'(NUM_BANKS);
  localparam logic [NEED_W-1:0]    NEED_SAT = NEED_W'(NUM_BANKS + 1);
  localparam logic [NUM_BANKS-1:0] ONES     = {NUM_BANKS{1'b1}};

  function automatic logic [CNT_W-1:0] clamp_total(input logic [6:0] t);
    if (t == 7'd0) begin
      return CNT_W'(1);
    end else if (t > 7'(NUM_BANKS)) begin
      return BANKS_C;
    end
    return CNT_W'(t);
  endfunction

  function automatic logic [CNT_W-1:0] clamp_resv(input logic [6:0] r,
                                                  input logic [CNT_W-1:0] t);
    if (r > 7'(t)) begin
      return t;
    end
    return CNT_W'(r);
  endfunction

  // configuration
  logic [4:0] shift_q;
  logic [7:0] hdr_q;
  logic [6:0] resv_q, total_q;
  logic [4:0] eff_shift;
  logic [CNT_W-1:0] total_eff, resv_eff, clear_tail;
  logic [6:0] new_resv, new_total;
  logic clear_blocks;

  // walk state
  logic req_q;
  logic [NEED_W-1:0] need_q, need_in;
  logic [CNT_W-1:0]  target_q, target_in;
  logic [CNT_W-1:0]  b_q, b_d, tail_q, len_q;
  logic [NUM_BANKS-1:0] active_q, valid_q;
  logic rd_valid_q;

  // table access
  logic [ENT_W-1:0] rdata, wdata;
  logic [IDX_W-1:0] waddr;
  logic             we;
  logic [CNT_W-1:0] len_eff, n, base, split_at;
  logic             free_eff;

  // sizing
  logic [26:0] bytes;
  logic [27:0] rounded, quot;
  logic [25:0] off_diff, tq;
  logic [25:0] pay;
  logic [CNT_W:0] range_end;
  logic [NUM_BANKS-1:0] range_mask;

  // results
  status_e     res_status_q;
  logic [IDX_W-1:0] res_start_q;
  logic [25:0] res_pay_q;
  logic [NUM_BANKS-1:0] res_mask_q;

  always_comb begin
    if (shift_q < SHIFT_MIN) begin
      eff_shift = SHIFT_MIN;
    end else if (shift_q > SHIFT_MAX) begin
      eff_shift = SHIFT_MAX;
    end else begin
      eff_shift = shift_q;
    end
    total_eff    = clamp_total(total_q);
    resv_eff     = clamp_resv(resv_q, total_eff);
    clear_blocks = cfg_we_i && (cfg_addr_i == CFG_RESERVED_BANKS ||
                                cfg_addr_i == CFG_TOTAL_BANKS);
    new_resv  = (cfg_we_i && cfg_addr_i == CFG_RESERVED_BANKS) ? cfg_wdata_i[6:0] : resv_q;
    new_total = (cfg_we_i && cfg_addr_i == CFG_TOTAL_BANKS) ? cfg_wdata_i[6:0] : total_q;
    clear_tail = clamp_resv(new_resv, clamp_total(new_total));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= RESET_SHIFT;
      hdr_q   <= RESET_HEADER;
      resv_q  <= RESET_RESERVED;
      total_q <= RESET_TOTAL;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_BANK_SHIFT:     shift_q <= cfg_wdata_i[4:0];
        CFG_HEADER_BYTES:   hdr_q   <= cfg_wdata_i;
        CFG_RESERVED_BANKS: resv_q  <= cfg_wdata_i[6:0];
        CFG_TOTAL_BANKS:    total_q <= cfg_wdata_i[6:0];
        default:            shift_q <= shift_q;
      endcase
    end
  end

  // bank count and free target of the incoming item
  always_comb begin
    bytes   = 27'(request_bytes_i) + 27'(hdr_q);
    rounded = 28'(bytes) + ((28'd1 << eff_shift) - 28'd1);
    quot    = rounded >> eff_shift;
    if (quot == 28'd0) begin
      need_in = NEED_W'(1);
    end else if (quot > 28'(NUM_BANKS)) begin
      need_in = NEED_SAT;
    end else begin
      need_in = NEED_W'(quot);
    end
    off_diff = free_offset_i - 26'(hdr_q);
    tq       = off_diff >> eff_shift;
    if (free_offset_i < 26'(hdr_q) || tq >= 26'(NUM_BANKS)) begin
      target_in = BANKS_C;
    end else begin
      target_in = CNT_W'(tq);
    end
  end

  ffba_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_BANKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (b_d[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    len_eff  = rd_valid_q ? rdata[CNT_W-1:0] : '0;
    free_eff = rd_valid_q && rdata[CNT_W];
    n        = need_q[CNT_W-1:0];
    split_at = CNT_W'(b_q + n);
    base     = (cmd_i.wr_op == WR_APPEND) ? tail_q : b_q;

    if (cmd_i.load) begin
      b_d = resv_eff;
    end else if (cmd_i.step) begin
      b_d = CNT_W'(b_q + len_eff);
    end else begin
      b_d = b_q;
    end

    we    = 1'b1;
    waddr = b_q[IDX_W-1:0];
    wdata = {1'b0, n};
    unique case (cmd_i.wr_op)
      WR_HIT:    wdata = {1'b0, n};
      WR_SPLIT: begin
        waddr = split_at[IDX_W-1:0];
        wdata = {1'b1, CNT_W'(len_q - n)};
      end
      WR_FREE:   wdata = {1'b1, len_eff};
      WR_APPEND: waddr = tail_q[IDX_W-1:0];
      default:   we = 1'b0;
    endcase

    pay       = 26'(26'(base) << eff_shift) + 26'(hdr_q);
    range_end = (CNT_W + 1)'(base) + (CNT_W + 1)'(n);
    range_mask = (ONES << base) &
                 ((range_end >= (CNT_W + 1)'(NUM_BANKS)) ? ONES : ~(ONES << range_end));

    sts_o.in_range    = (b_q < tail_q) && (len_eff != '0);
    sts_o.is_free_req = (req_q == REQ_FREE);
    sts_o.alloc_fit   = free_eff && (NEED_W'(len_eff) >= need_q);
    sts_o.free_match  = (b_q == target_q);
    sts_o.need_split  = NEED_W'(len_eff) > need_q;
    sts_o.tail_fit    = (tail_q < total_eff) && (need_q <= NEED_W'(total_eff - tail_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q        <= '0;
      tail_q     <= CNT_W'(RESET_RESERVED);
      active_q   <= '0;
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      b_q        <= b_d;
      rd_valid_q <= (b_d < BANKS_C) && valid_q[b_d[IDX_W-1:0]];
      if (clear_blocks) begin
        valid_q <= '0;
        tail_q  <= clear_tail;
      end else begin
        if (we) begin
          valid_q[waddr] <= 1'b1;
        end
        if (cmd_i.wr_op == WR_APPEND) begin
          tail_q <= CNT_W'(tail_q + n);
        end
      end
      if (cmd_i.wr_op == WR_HIT || cmd_i.wr_op == WR_APPEND) begin
        active_q <= active_q | range_mask;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q    <= req_type_i;
      need_q   <= need_in;
      target_q <= target_in;
    end
    if (cmd_i.wr_op == WR_HIT) begin
      len_q <= len_eff;
    end
    if (cmd_i.wr_op == WR_HIT || cmd_i.wr_op == WR_APPEND) begin
      res_status_q <= STATUS_OK;
      res_start_q  <= base[IDX_W-1:0];
      res_pay_q    <= pay;
      res_mask_q   <= range_mask & ~active_q;
    end else if (cmd_i.wr_op == WR_FREE) begin
      res_status_q <= STATUS_OK;
      res_start_q  <= base[IDX_W-1:0];
      res_pay_q    <= pay;
      res_mask_q   <= '0;
    end else if (cmd_i.fail) begin
      res_status_q <= (req_q == REQ_FREE) ? STATUS_UNKNOWN : STATUS_NO_ROOM;
      res_start_q  <= '0;
      res_pay_q    <= '0;
      res_mask_q   <= '0;
    end
  end

  assign status_o          = res_status_q;
  assign start_bank_o      = 6'(res_start_q);
  assign payload_offset_o  = res_pay_q;
  assign new_active_mask_o = 64'(res_mask_q);

endmodule
`default_nettype wire

// File: design/first_fit_bank_allocator.sv
// Top level of the first-fit bank allocator.
// Usage:
//   Pulse start_i with req_type_i, request_bytes_i and free_offset_i; the item is
//   taken at a clock edge where start_i is high and busy_o is low.
//   One result per item: done_o is high for exactly one cycle and status_o,
//   start_bank_o, payload_offset_o and new_active_mask_o hold the result in it.
//   The receiver cannot stall; the result must be taken in that cycle.
//   Sequence: the accepted item passes through the WALK state, which steps past
//   one block per cycle through the block table RAM (registered read), then
//   SPLIT when a reused block is split, and ends in DONE, where done_o is high.
//   A new item may be accepted in the cycle that done_o is high, but none is
//   taken while busy_o is high.
//   Configuration: cfg_we_i writes cfg_wdata_i to register cfg_addr_i; the user
//   must write only while idle, as the block itself does not enforce it.
//   Writing reserved_banks or total_banks empties the block list at once.
//   Reset clears the block list, bank activations and the sequencer; the
//   registers take their default values. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_bank_allocator #(
  parameter int unsigned NUM_BANKS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        req_type_i,
  input  wire logic [25:0] request_bytes_i,
  input  wire logic [25:0] free_offset_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [5:0]       start_bank_o,
  output logic [25:0]      payload_offset_o,
  output logic [63:0]      new_active_mask_o
);
  import ffba_pkg::*;

  ffba_cmd_t cmd;
  ffba_sts_t sts;

  ffba_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  ffba_datapath #(
    .NUM_BANKS (NUM_BANKS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_addr_i        (cfg_addr_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .req_type_i        (req_type_i),
    .request_bytes_i   (request_bytes_i),
    .free_offset_i     (free_offset_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .status_o          (status_o),
    .start_bank_o      (start_bank_o),
    .payload_offset_o  (payload_offset_o),
    .new_active_mask_o (new_active_mask_o)
  );

endmodule
`default_nettype wire

// File: design/ffba_checker.sv
// Port-level checks of the bank allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_bank_allocator_macros.svh"
module ffba_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic        done_o,
  input wire logic [1:0]  status_o,
  input wire logic [5:0]  start_bank_o,
  input wire logic [25:0] payload_offset_o,
  input wire logic [63:0] new_active_mask_o
);
  import ffba_pkg::*;

  `FFBA_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o, busy_o, "accepted item did not raise busy")
  `FFBA_ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o, "result strobe longer than one cycle")
  `FFBA_ASSERT_IMPL(a_done_idle, clk_i, rst_ni, done_o, !busy_o, "result strobe while busy")
  `FFBA_ASSERT_IMPL(a_fail_zero, clk_i, rst_ni, done_o && status_o != STATUS_OK, start_bank_o == 6'd0 && payload_offset_o == 26'd0 && new_active_mask_o == 64'd0, "failed item carries data")

endmodule

bind first_fit_bank_allocator ffba_checker u_checker (.*);
`default_nettype wire

// File: sim/tb_first_fit_bank_allocator.sv
// Testbench for the first-fit bank allocator: directed and random requests against a predictor.
`timescale 1ns / 1ps
module tb_first_fit_bank_allocator;
  import ffba_pkg::*;

  localparam int unsigned NUM_BANKS = 64;

  typedef struct packed {
    status_e     status;
    logic [5:0]  start_bank;
    logic [25:0] payload_offset;
    logic [63:0] new_active_mask;
  } bank_grant_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_addr_i;
  logic [7:0]  cfg_wdata_i;
  logic        start_i;
  logic        busy_o;
  logic        req_type_i;
  logic [25:0] request_bytes_i;
  logic [25:0] free_offset_i;
  logic        done_o;
  logic [1:0]  status_o;
  logic [5:0]  start_bank_o;
  logic [25:0] payload_offset_o;
  logic [63:0] new_active_mask_o;

  first_fit_bank_allocator #(
    .NUM_BANKS(NUM_BANKS)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .req_type_i       (req_type_i),
    .request_bytes_i  (request_bytes_i),
    .free_offset_i    (free_offset_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .start_bank_o     (start_bank_o),
    .payload_offset_o (payload_offset_o),
    .new_active_mask_o(new_active_mask_o)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state
  logic [4:0]  shift_reg;
  logic [7:0]  header_reg;
  logic [6:0]  reserved_reg;
  logic [6:0]  total_reg;
  logic [6:0]  block_banks [NUM_BANKS];
  bit          block_free [NUM_BANKS];
  logic [63:0] banks_on;
  int unsigned tail_bank;

  bank_grant_t expected_grants [$];
  int unsigned mismatch_count;

  function automatic int unsigned eff_shift();
    if (shift_reg < SHIFT_MIN) return SHIFT_MIN;
    if (shift_reg > SHIFT_MAX) return SHIFT_MAX;
    return shift_reg;
  endfunction

  function automatic int unsigned eff_total();
    if (total_reg < 1) return 1;
    if (total_reg > NUM_BANKS) return NUM_BANKS;
    return total_reg;
  endfunction

  function automatic int unsigned eff_reserved();
    int unsigned t;
    t = eff_total();
    return (reserved_reg > t) ? t : reserved_reg;
  endfunction

  function automatic void clear_block_list();
    for (int i = 0; i < NUM_BANKS; i++) begin
      block_banks[i] = '0;
      block_free[i]  = 1'b0;
    end
    tail_bank = eff_reserved();
  endfunction

  function automatic logic [63:0] claim_banks(int unsigned first, int unsigned n);
    logic [63:0] range;
    range = '0;
    for (int unsigned i = first; i < first + n && i < 64; i++) range[i] = 1'b1;
    range    = range & ~banks_on;
    banks_on = banks_on | range;
    return range;
  endfunction

  function automatic logic [25:0] payload_at(int unsigned b);
    return 26'((64'(b) << eff_shift()) + 64'(header_reg));
  endfunction

  function automatic bank_grant_t predict_bank_result(req_type_e kind, logic [25:0] bytes,
                                                      logic [25:0] offset);
    bank_grant_t r;
    int unsigned sh, b, len, n, steps;
    logic [63:0] need, target;
    r  = '0;
    sh = eff_shift();
    b  = eff_reserved();
    if (kind == REQ_ALLOC) begin
      need = (64'(bytes) + 64'(header_reg) + (64'd1 << sh) - 64'd1) >> sh;
      if (need == 0) need = 1;
      for (steps = 0; steps < NUM_BANKS && b < tail_bank && b < 64; steps++) begin
        len = block_banks[b];
        if (len == 0) break;
        if (block_free[b] && len >= need) begin
          n = need[31:0];
          block_free[b] = 1'b0;
          if (len > n && b + n < 64) begin
            block_banks[b + n] = 7'(len - n);
            block_free[b + n]  = 1'b1;
          end
          block_banks[b]    = 7'(n);
          r.start_bank      = b[5:0];
          r.payload_offset  = payload_at(b);
          r.new_active_mask = claim_banks(b, n);
          return r;
        end
        b += len;
      end
      if (tail_bank < eff_total() && need <= 64'(eff_total() - tail_bank)) begin
        n = need[31:0];
        b = tail_bank;
        block_banks[b]    = 7'(n);
        block_free[b]     = 1'b0;
        tail_bank         = b + n;
        r.start_bank      = b[5:0];
        r.payload_offset  = payload_at(b);
        r.new_active_mask = claim_banks(b, n);
      end else begin
        r.status = STATUS_NO_ROOM;
      end
    end else if (offset < header_reg) begin
      r.status = STATUS_UNKNOWN;
    end else begin
      target = (64'(offset) - 64'(header_reg)) >> sh;
      for (steps = 0; steps < NUM_BANKS && b < tail_bank && b < 64; steps++) begin
        len = block_banks[b];
        if (len == 0) break;
        if (b == target) begin
          block_free[b]    = 1'b1;
          r.start_bank     = b[5:0];
          r.payload_offset = payload_at(b);
          return r;
        end
        b += len;
      end
      r.status = STATUS_UNKNOWN;
    end
    return r;
  endfunction

  // Start bank of a random block in the list, or -1 when the list is empty
  function automatic int live_block_start();
    int unsigned b;
    int starts [$];
    b = eff_reserved();
    while (b < tail_bank && b < 64 && block_banks[b] != 0) begin
      starts.push_back(b);
      b += block_banks[b];
    end
    if (starts.size() == 0) return -1;
    return starts[$urandom_range(0, starts.size() - 1)];
  endfunction

  function automatic logic [25:0] fitting_request_bytes();
    int unsigned k, bsize, want;
    bsize = 1 << eff_shift();
    k     = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4);
    want  = $urandom_range((k - 1) * bsize + 1, k * bsize);
    return (want > header_reg) ? 26'(want - header_reg) : 26'd0;
  endfunction

  task automatic send_item(req_type_e kind, logic [25:0] bytes, logic [25:0] offset);
    @(negedge clk_i);
    start_i         <= 1'b1;
    req_type_i      <= kind;
    request_bytes_i <= bytes;
    free_offset_i   <= offset;
    do @(posedge clk_i); while (busy_o);
    expected_grants.push_back(predict_bank_result(kind, bytes, offset));
  endtask

  task automatic idle_for(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
  endtask

  task automatic wait_until_drained();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [7:0] value);
    @(negedge clk_i);
    start_i     <= 1'b0;
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_BANK_SHIFT:     shift_reg = value[4:0];
      CFG_HEADER_BYTES:   header_reg = value;
      CFG_RESERVED_BANKS: begin
        reserved_reg = value[6:0];
        clear_block_list();
      end
      CFG_TOTAL_BANKS: begin
        total_reg = value[6:0];
        clear_block_list();
      end
      default: ;
    endcase
  endtask

  task automatic send_random_item();
    int unsigned pick, bsize;
    int blk;
    req_type_e kind;
    logic [25:0] bytes, offset;
    pick   = $urandom_range(0, 99);
    bsize  = 1 << eff_shift();
    kind   = REQ_ALLOC;
    bytes  = 26'($urandom);
    offset = 26'($urandom);
    if (pick < 55) begin
      bytes = fitting_request_bytes();
    end else if (pick < 85) begin
      blk = live_block_start();
      if (blk < 0) begin
        bytes = fitting_request_bytes();
      end else begin
        kind   = REQ_FREE;
        offset = 26'((64'(blk) << eff_shift()) + 64'(header_reg) +
                     64'($urandom_range(0, bsize - 1)));
      end
    end else if (pick < 90) begin
      kind   = REQ_FREE;
      offset = 26'($urandom_range(0, 64 * bsize));
    end else if (pick < 95) begin
      kind   = REQ_FREE;
      offset = 26'($urandom_range(0, header_reg));
    end else begin
      kind = req_type_e'($urandom_range(0, 1));
    end
    send_item(kind, bytes, offset);
  endtask

  // Reset defaults: fresh appends, frees, lookup misses, split reuse, exact fill
  task automatic test_alloc_free_basics();
    send_item(REQ_ALLOC, 26'd0,        26'h3FFFFFF);
    send_item(REQ_ALLOC, 26'd8192,     26'd0);
    send_item(REQ_ALLOC, 26'd4064,     26'd0);
    send_item(REQ_FREE,  26'h3FFFFFF,  26'd8224);
    send_item(REQ_FREE,  26'd0,        26'd12224);
    send_item(REQ_FREE,  26'd0,        26'd10);
    send_item(REQ_FREE,  26'd0,        26'd12320);
    send_item(REQ_FREE,  26'd0,        26'd258080);
    send_item(REQ_ALLOC, 26'd100,      26'd0);
    send_item(REQ_ALLOC, 26'd5000,     26'd0);
    send_item(REQ_ALLOC, 26'h3FFFFFF,  26'd0);
    send_item(REQ_ALLOC, 26'd233472,   26'd0);
    send_item(REQ_ALLOC, 26'd0,        26'd0);
    send_item(REQ_FREE,  26'd0,        26'h3FFFFFF);
  endtask

  // Out-of-range register values, empty request, whole-memory block
  task automatic test_register_limits();
    wait_until_drained();
    write_register(CFG_BANK_SHIFT, 8'd0);
    write_register(CFG_HEADER_BYTES, 8'd0);
    write_register(CFG_RESERVED_BANKS, 8'd0);
    write_register(CFG_TOTAL_BANKS, 8'd0);
    send_item(REQ_ALLOC, 26'd0, 26'd0);
    send_item(REQ_ALLOC, 26'd1, 26'd0);
    wait_until_drained();
    write_register(CFG_TOTAL_BANKS, 8'd127);
    write_register(CFG_BANK_SHIFT, 8'd31);
    send_item(REQ_ALLOC, 26'h3FFFFFF, 26'd0);
    wait_until_drained();
    write_register(CFG_HEADER_BYTES, 8'd255);
    send_item(REQ_FREE, 26'd0, 26'd255);
    send_item(REQ_FREE, 26'd0, 26'd254);
    wait_until_drained();
    write_register(CFG_RESERVED_BANKS, 8'd127);
    send_item(REQ_ALLOC, 26'd0, 26'd0);
  endtask

  task automatic test_random_traffic();
    int unsigned burst, sent;
    logic [7:0] cfg [4];
    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        0: cfg = '{8'd4,  8'd0,   8'd0,  8'd64};
        1: cfg = '{8'd20, 8'd255, 8'd0,  8'd64};
        2: cfg = '{8'd12, 8'd32,  8'd63, 8'd64};
        3: cfg = '{8'd0,  8'd255, 8'd2,  8'd127};
        default: begin
          cfg[0] = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) :
                                                    $urandom_range(4, 20));
          cfg[1] = 8'($urandom_range(0, 255));
          cfg[2] = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) :
                                                    $urandom_range(0, 8));
          cfg[3] = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) :
                                                    $urandom_range(16, 64));
        end
      endcase
      wait_until_drained();
      write_register(CFG_BANK_SHIFT, cfg[0]);
      write_register(CFG_HEADER_BYTES, cfg[1]);
      write_register(CFG_RESERVED_BANKS, cfg[2]);
      write_register(CFG_TOTAL_BANKS, cfg[3]);
      sent = 0;
      while (sent < 115) begin
        burst = $urandom_range(1, 24);
        repeat (burst) begin
          send_random_item();
          sent++;
        end
        if ($urandom_range(0, 15) == 0) wait_until_drained();
        else if ($urandom_range(0, 2) != 0) idle_for($urandom_range(1, 8));
      end
    end
  endtask

  always @(posedge clk_i) begin : result_check
    bank_grant_t want;
    if (rst_ni && done_o) begin
      if (expected_grants.size() == 0) begin
        $error("result with no request outstanding");
        mismatch_count++;
      end else begin
        want = expected_grants.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatch_count++;
        end
        if (start_bank_o !== want.start_bank) begin
          $error("start_bank: expected %0d, got %0d", want.start_bank, start_bank_o);
          mismatch_count++;
        end
        if (payload_offset_o !== want.payload_offset) begin
          $error("payload_offset: expected %0d, got %0d", want.payload_offset,
                 payload_offset_o);
          mismatch_count++;
        end
        if (new_active_mask_o !== want.new_active_mask) begin
          $error("new_active_mask: expected %h, got %h", want.new_active_mask,
                 new_active_mask_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("tb_first_fit_bank_allocator: FAIL");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_addr_i      = CFG_BANK_SHIFT;
    cfg_wdata_i     = '0;
    start_i         = 1'b0;
    req_type_i      = REQ_ALLOC;
    request_bytes_i = '0;
    free_offset_i   = '0;
    mismatch_count  = 0;
    shift_reg       = RESET_SHIFT;
    header_reg      = RESET_HEADER;
    reserved_reg    = RESET_RESERVED;
    total_reg       = RESET_TOTAL;
    banks_on        = '0;
    clear_block_list();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_alloc_free_basics();
    test_register_limits();
    test_random_traffic();

    wait_until_drained();
    repeat (NUM_BANKS + 8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_first_fit_bank_allocator: PASS");
    end else begin
      $display("tb_first_fit_bank_allocator: FAIL");
    end
    $finish;
  end

endmodule

// File: first_fit_bank_allocator.f
+incdir+design
design/ffba_pkg.sv
design/ffba_ram.sv
design/ffba_ctrl.sv
design/ffba_datapath.sv
design/first_fit_bank_allocator.sv
design/ffba_checker.sv
sim/tb_first_fit_bank_allocator.sv
